/* hdl/tdpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tdpd_pkg;

    // wheels served by ports, and wheels actually driven
    localparam int NWHEEL      = 3;
    localparam int WHEEL_COUNT = 3;
    localparam int PWM_RANGE   = 100;
    localparam int PWM_W       = $clog2(PWM_RANGE + 1);

    localparam int GAIN_W  = 16;
    localparam int COUNT_W = 32;
    localparam int ERR_W   = COUNT_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int SUM_W   = 48;
    localparam int DUTY_W  = 7;
    localparam int Q_SHIFT = 16;
    localparam int MAG_W   = Q_SHIFT + 1;

    // register stages inside one lane
    localparam int NSTAGE = 5;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_KP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD = 2'd2;

    localparam logic [GAIN_W-1:0] KP_RESET = 16'd524;
    localparam logic [GAIN_W-1:0] KI_RESET = 16'd131;
    localparam logic [GAIN_W-1:0] KD_RESET = 16'd852;

    localparam logic CMD_STOP = 1'b1;

    typedef struct packed {
        logic [NSTAGE-1:0] load;
        logic              update;
    } lane_ctrl_t;

    typedef struct packed {
        logic              neg;
        logic [DUTY_W-1:0] duty;
    } lane_res_t;

    typedef struct packed {
        logic load;
        logic valid;
        logic stop;
    } merge_ctrl_t;

endpackage

`default_nettype wire

/* hdl/tdpd_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module tdpd_lane (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire tdpd_pkg::lane_ctrl_t                  ctrl,
    input  wire logic [tdpd_pkg::GAIN_W-1:0]           kp_gain,
    input  wire logic [tdpd_pkg::GAIN_W-1:0]           ki_gain,
    input  wire logic [tdpd_pkg::GAIN_W-1:0]           kd_gain,
    input  wire logic signed [tdpd_pkg::COUNT_W-1:0]   measured_count,
    input  wire logic signed [tdpd_pkg::COUNT_W-1:0]   target_count,
    output tdpd_pkg::lane_res_t                        res
);
    import tdpd_pkg::*;

    localparam int LO_W   = SUM_W / 2;
    localparam int P_W    = GAIN_W + 1 + ERR_W;
    localparam int D_W    = GAIN_W + 1 + DIFF_W;
    localparam int ILO_W  = GAIN_W + LO_W;
    localparam int IHI_W  = GAIN_W + 1 + SUM_W - LO_W;
    localparam int PD_W   = D_W + 1;
    localparam int I_W    = GAIN_W + SUM_W;
    localparam int ACC_W  = I_W + 1;
    localparam int PROD_W = MAG_W + PWM_W + DUTY_W;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ONE_Q16 = ACC_W'(65536);
    localparam logic signed [ACC_W-1:0] NEG_ONE = -ONE_Q16;
    localparam logic [MAG_W-1:0]        MAG_ONE = {1'b1, {(MAG_W-1){1'b0}}};

    // controller state
    logic signed [SUM_W-1:0]  error_sum_reg;
    logic signed [ERR_W-1:0]  previous_error_reg;

    logic signed [ERR_W-1:0]  err_a_reg;
    logic signed [ERR_W-1:0]  err_b_reg;
    logic signed [DIFF_W-1:0] diff_b_reg;
    logic signed [SUM_W-1:0]  sum_b_reg;
    logic signed [P_W-1:0]    p_c_reg;
    logic signed [D_W-1:0]    d_c_reg;
    logic [ILO_W-1:0]         ilo_c_reg;
    logic signed [IHI_W-1:0]  ihi_c_reg;
    logic signed [PD_W-1:0]   pd_d_reg;
    logic signed [I_W-1:0]    i_d_reg;
    logic                     neg_e_reg;
    logic [MAG_W-1:0]         mag_e_reg;

    logic signed [ERR_W-1:0]  err_a_next;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_b_next;
    logic signed [DIFF_W-1:0] diff_b_next;
    logic signed [P_W-1:0]    p_c_next;
    logic signed [D_W-1:0]    d_c_next;
    logic [ILO_W-1:0]         ilo_c_next;
    logic signed [IHI_W-1:0]  ihi_c_next;
    logic signed [PD_W-1:0]   pd_d_next;
    logic signed [I_W-1:0]    i_d_next;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_neg;
    logic                     neg_e_next;
    logic [MAG_W-1:0]         mag_e_next;
    logic [PROD_W-1:0]        duty_prod;

    always_comb
    begin
        err_a_next = ERR_W'(measured_count) - ERR_W'(target_count);

        // integral with saturation at the 48-bit limits
        sum_wide = (SUM_W+1)'(error_sum_reg) + (SUM_W+1)'(err_a_reg);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_b_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_b_next = sum_wide[SUM_W-1:0];
        end
        diff_b_next = DIFF_W'(err_a_reg) - DIFF_W'(previous_error_reg);

        p_c_next   = P_W'($signed({1'b0, kp_gain})) * P_W'(err_b_reg);
        d_c_next   = D_W'($signed({1'b0, kd_gain})) * D_W'(diff_b_reg);
        ilo_c_next = ILO_W'(ki_gain) * ILO_W'(sum_b_reg[LO_W-1:0]);
        ihi_c_next = IHI_W'($signed({1'b0, ki_gain}))
                     * IHI_W'($signed(sum_b_reg[SUM_W-1:LO_W]));

        pd_d_next = PD_W'(p_c_reg) + PD_W'(d_c_reg);
        i_d_next  = {ihi_c_reg[I_W-LO_W-1:0], {LO_W{1'b0}}} + I_W'(ilo_c_reg);

        // full-width sum keeps the true sign, so the clamp is exact
        acc     = ACC_W'(i_d_reg) + ACC_W'(pd_d_reg);
        acc_neg = -acc;
        if (acc > ONE_Q16)
        begin
            neg_e_next = 1'b1;
            mag_e_next = MAG_ONE;
        end
        else if (acc < NEG_ONE)
        begin
            neg_e_next = 1'b0;
            mag_e_next = MAG_ONE;
        end
        else if (acc > 0)
        begin
            neg_e_next = 1'b1;
            mag_e_next = acc[MAG_W-1:0];
        end
        else
        begin
            neg_e_next = 1'b0;
            mag_e_next = acc_neg[MAG_W-1:0];
        end

        duty_prod = PROD_W'(mag_e_reg) * PROD_W'(PWM_RANGE);
        res.neg   = neg_e_reg;
        res.duty  = duty_prod[Q_SHIFT +: DUTY_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg      <= '0;
            previous_error_reg <= '0;
        end
        else if (ctrl.update)
        begin
            error_sum_reg      <= sum_b_next;
            previous_error_reg <= err_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            err_a_reg <= err_a_next;
        end
        if (ctrl.load[1])
        begin
            err_b_reg  <= err_a_reg;
            diff_b_reg <= diff_b_next;
            sum_b_reg  <= sum_b_next;
        end
        if (ctrl.load[2])
        begin
            p_c_reg   <= p_c_next;
            d_c_reg   <= d_c_next;
            ilo_c_reg <= ilo_c_next;
            ihi_c_reg <= ihi_c_next;
        end
        if (ctrl.load[3])
        begin
            pd_d_reg <= pd_d_next;
            i_d_reg  <= i_d_next;
        end
        if (ctrl.load[4])
        begin
            neg_e_reg <= neg_e_next;
            mag_e_reg <= mag_e_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/tdpd_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

module tdpd_merge (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tdpd_pkg::merge_ctrl_t          ctrl,
    input  wire tdpd_pkg::lane_res_t            lane_res [tdpd_pkg::NWHEEL],
    output logic                                out_valid,
    output logic [tdpd_pkg::DUTY_W-1:0]         fwd_duty [tdpd_pkg::NWHEEL],
    output logic [tdpd_pkg::DUTY_W-1:0]         rev_duty [tdpd_pkg::NWHEEL]
);
    import tdpd_pkg::*;

    logic              out_valid_reg;
    logic [DUTY_W-1:0] fwd_reg [NWHEEL];
    logic [DUTY_W-1:0] rev_reg [NWHEEL];
    logic [DUTY_W-1:0] fwd_next [NWHEEL];
    logic [DUTY_W-1:0] rev_next [NWHEEL];

    // steer each lane's magnitude to one side; stop gives all zeros
    always_comb
    begin
        for (int w = 0; w < NWHEEL; w++)
        begin
            fwd_next[w] = '0;
            rev_next[w] = '0;
            if (ctrl.stop != CMD_STOP)
            begin
                if (lane_res[w].neg)
                begin
                    rev_next[w] = lane_res[w].duty;
                end
                else
                begin
                    fwd_next[w] = lane_res[w].duty;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            out_valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load && ctrl.valid)
        begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign fwd_duty  = fwd_reg;
    assign rev_duty  = rev_reg;

endmodule

`default_nettype wire

/* hdl/three_wheel_pid_pwm_drive_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// three-wheel position pid with pwm duty outputs. one control tick is one input
// transaction; it enters the first of five lane stages at the edge that accepts it,
// passes the other lane stages and leaves as its result through the output register.
// a new tick is taken every cycle while the input is not stalled, since each wheel's
// integral and previous error are updated as a tick moves into the second lane stage,
// just in time for the next tick to read them. the input stalls only when every stage
// is full and the result is stalled. the three wheels run in parallel lanes; the
// 16 x 48 integral product is split into two partial products over two stages. a stop
// command gives all-zero duties and leaves the controller state alone. the user must
// write gains only while no transaction is in flight; the block does not enforce it.

module three_wheel_pid_pwm_drive_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write,
    input  wire logic [tdpd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [tdpd_pkg::GAIN_W-1:0]            cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic                                   command,
    input  wire logic signed [tdpd_pkg::COUNT_W-1:0]    measured_count_0,
    input  wire logic signed [tdpd_pkg::COUNT_W-1:0]    measured_count_1,
    input  wire logic signed [tdpd_pkg::COUNT_W-1:0]    measured_count_2,
    input  wire logic signed [tdpd_pkg::COUNT_W-1:0]    target_count_0,
    input  wire logic signed [tdpd_pkg::COUNT_W-1:0]    target_count_1,
    input  wire logic signed [tdpd_pkg::COUNT_W-1:0]    target_count_2,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [tdpd_pkg::DUTY_W-1:0]                 forward_duty_0,
    output logic [tdpd_pkg::DUTY_W-1:0]                 reverse_duty_0,
    output logic [tdpd_pkg::DUTY_W-1:0]                 forward_duty_1,
    output logic [tdpd_pkg::DUTY_W-1:0]                 reverse_duty_1,
    output logic [tdpd_pkg::DUTY_W-1:0]                 forward_duty_2,
    output logic [tdpd_pkg::DUTY_W-1:0]                 reverse_duty_2
);
    import tdpd_pkg::*;

    logic [GAIN_W-1:0]         kp_reg;
    logic [GAIN_W-1:0]         ki_reg;
    logic [GAIN_W-1:0]         kd_reg;
    logic [NSTAGE-1:0]         v_reg;
    logic [NSTAGE-1:0]         stop_reg;
    logic [NSTAGE:0]           en;
    logic                      en_out;
    lane_ctrl_t                lane_ctrl;
    merge_ctrl_t               merge_ctrl;
    lane_res_t                 lane_res [NWHEEL];
    logic signed [COUNT_W-1:0] meas [NWHEEL];
    logic signed [COUNT_W-1:0] targ [NWHEEL];
    logic [DUTY_W-1:0]         fwd_duty [NWHEEL];
    logic [DUTY_W-1:0]         rev_duty [NWHEEL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= KP_RESET;
            ki_reg <= KI_RESET;
            kd_reg <= KD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KP:  kp_reg <= cfg_data;
                REG_KI:  ki_reg <= cfg_data;
                REG_KD:  kd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage can take a transaction if it is empty or its content moves on
    always_comb
    begin
        en_out     = !out_valid || !out_stall;
        en[NSTAGE] = en_out;
        for (int k = NSTAGE - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        in_stall = !en[0];

        lane_ctrl.load[0] = en[0] && in_valid;
        for (int k = 1; k < NSTAGE; k++)
        begin
            lane_ctrl.load[k] = en[k] && v_reg[k-1];
        end
        lane_ctrl.update = en[1] && v_reg[0] && (stop_reg[0] != CMD_STOP);

        merge_ctrl.load  = en_out;
        merge_ctrl.valid = v_reg[NSTAGE-1];
        merge_ctrl.stop  = stop_reg[NSTAGE-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            stop_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0]    <= in_valid;
                stop_reg[0] <= command;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    v_reg[k]    <= v_reg[k-1];
                    stop_reg[k] <= stop_reg[k-1];
                end
            end
        end
    end

    assign meas[0] = measured_count_0;
    assign meas[1] = measured_count_1;
    assign meas[2] = measured_count_2;
    assign targ[0] = target_count_0;
    assign targ[1] = target_count_1;
    assign targ[2] = target_count_2;

    for (genvar w = 0; w < NWHEEL; w++)
    begin : g_lane
        if (w < WHEEL_COUNT)
        begin : g_used
            tdpd_lane u_lane (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctrl           (lane_ctrl),
                .kp_gain        (kp_reg),
                .ki_gain        (ki_reg),
                .kd_gain        (kd_reg),
                .measured_count (meas[w]),
                .target_count   (targ[w]),
                .res            (lane_res[w])
            );
        end
        else
        begin : g_unused
            assign lane_res[w] = '0;
        end
    end

    tdpd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (merge_ctrl),
        .lane_res  (lane_res),
        .out_valid (out_valid),
        .fwd_duty  (fwd_duty),
        .rev_duty  (rev_duty)
    );

    assign forward_duty_0 = fwd_duty[0];
    assign reverse_duty_0 = rev_duty[0];
    assign forward_duty_1 = fwd_duty[1];
    assign reverse_duty_1 = rev_duty[1];
    assign forward_duty_2 = fwd_duty[2];
    assign reverse_duty_2 = rev_duty[2];

    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v_reg[0] && out_valid && out_stall))
        else $error("input stalled while the pipeline can move");

    a_last_stage_reaches_output : assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NSTAGE-1] && en_out) |=> out_valid)
        else $error("transaction lost between last lane stage and output register");

    a_one_direction : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((forward_duty_0 == '0 || reverse_duty_0 == '0)
                    && (forward_duty_1 == '0 || reverse_duty_1 == '0)
                    && (forward_duty_2 == '0 || reverse_duty_2 == '0)))
        else $error("forward and reverse duty both driven on one wheel");

endmodule

`default_nettype wire
